@@ rtl/cof_pkg.sv @@
`default_nettype none
package cof_pkg;

  // Width of the coordinate values once they are brought below 2^16
  localparam int NW = 16;

  localparam int SQRT_STEPS   = 32;
  localparam int CORDIC_STEPS = 30;

  // Angles in Q30 and pi in Q28
  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [29:0] PI_Q28      = 30'd843314857;

  // How the result of one pair of circles is formed
  typedef enum logic [1:0] {
    K_ONE,
    K_ZERO,
    K_RATIO,
    K_LENS
  } kind_t;

  // Values that travel beside the lens math
  typedef struct packed {
    kind_t       kind;
    logic [31:0] rr2;
    logic [31:0] sr2;
  } side_t;

  // Arctangent of 2^-i in Q30, rounded to nearest
  function automatic logic [29:0] atan_q30(input int unsigned i);
    logic [29:0] v;
    unique case (i)
      0:       v = 30'd843314857;
      1:       v = 30'd497837829;
      2:       v = 30'd263043837;
      3:       v = 30'd133525159;
      4:       v = 30'd67021687;
      5:       v = 30'd33543516;
      6:       v = 30'd16775851;
      7:       v = 30'd8388437;
      8:       v = 30'd4194283;
      9:       v = 30'd2097149;
      default: v = 30'(64'd1 << (30 - i));
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ rtl/circle_overlap_fraction.sv @@
// Overlap fraction of a spread disc with a target disc.
// Input channel (in_*): one item is a pair of circles, centres signed and radii
// unsigned, all in Q8.8 at COORD_WIDTH bits. Result channel (out_*): the part of
// the spread disc's area that lies inside the target, unsigned Q1.16 (at the
// default RESULT_FRAC_BITS), 1.0 when the spread lies wholly inside.
// Throughput: one item per clock cycle while out_tready keeps the result channel
// moving. Every stage is a register with its own valid bit, so a new item enters
// each cycle while earlier ones are in flight. There are 78 + RESULT_FRAC_BITS
// register stages (94 at the default), set by the two 32-step square roots, the
// 30-step CORDIC arctangent pair and the one-bit-per-stage divider.
// A stage takes a new item when it is empty or when the stage after it moves,
// so a stall at out_tready fills the empty stages first and loses or repeats
// nothing; in_tready drops only once every stage is full.
// Reset (rst_n low at a clock edge) empties the pipeline; in-flight items are
// dropped and no result is shown until new items arrive.
`default_nettype none
module circle_overlap_fraction
  import cof_pkg::*;
#(
  parameter int COORD_WIDTH      = 16,
  parameter int RESULT_FRAC_BITS = 16
) (
  input  wire                                      clk,
  input  wire                                      rst_n,
  input  wire                                      in_tvalid,
  output logic                                     in_tready,
  // target_x, target_y, target_rad, spread_x, spread_y, spread_rad (lowest first)
  input  wire  [((6*COORD_WIDTH+7)/8)*8-1:0]       in_tdata,
  output logic                                     out_tvalid,
  input  wire                                      out_tready,
  // hit_fraction
  output logic [((RESULT_FRAC_BITS+8)/8)*8-1:0]    out_tdata
);

  localparam int CW     = COORD_WIDTH;
  localparam int FB     = RESULT_FRAC_BITS;
  localparam int QW     = FB + 1;
  localparam int VW     = (CW > NW) ? CW : NW;
  localparam int SHW    = $clog2(VW + 1);
  localparam int OUT_W  = ((FB + 8) / 8) * 8;

  typedef struct packed {
    logic [63:0] rad;
    logic [35:0] rem;
    logic [31:0] root;
  } sqv_t;

  typedef struct packed {
    sqv_t               p;
    sqv_t               q;
    logic signed [34:0] x1;
    logic signed [34:0] x2;
    side_t              side;
  } sq_t;

  typedef struct packed {
    logic signed [43:0] x;
    logic signed [43:0] y;
    logic signed [33:0] z;
  } cv_t;

  typedef struct packed {
    cv_t         a;
    cv_t         b;
    logic        aneg;
    logic        bneg;
    logic        azero;
    logic        bzero;
    logic [63:0] s;
    side_t       side;
  } co_t;

  typedef struct packed {
    logic [64:0]   rem;
    logic [63:0]   den;
    logic [QW-1:0] q;
    logic          done;
    logic [QW-1:0] fixed;
  } dv_t;

  // One digit of the square root
  function automatic sqv_t sqv_step(input sqv_t v);
    logic [35:0] rt;
    logic [35:0] tr;
    sqv_t        o;
    rt    = {v.rem[33:0], v.rad[63:62]};
    tr    = {2'b00, v.root, 2'b01};
    o.rad = {v.rad[61:0], 2'b00};
    if (rt >= tr) begin
      o.rem  = rt - tr;
      o.root = {v.root[30:0], 1'b1};
    end else begin
      o.rem  = rt;
      o.root = {v.root[30:0], 1'b0};
    end
    return o;
  endfunction

  function automatic sq_t sq_stage(input sq_t v);
    sq_t o;
    o   = v;
    o.p = sqv_step(v.p);
    o.q = sqv_step(v.q);
    return o;
  endfunction

  // One vectoring rotation; shifts of a negative y truncate toward zero
  function automatic cv_t cv_step(input cv_t v, input int unsigned i);
    logic signed [43:0] xs;
    logic signed [43:0] ys;
    logic signed [43:0] ny;
    cv_t                o;
    xs = v.x >>> i;
    ny = -v.y;
    if (!v.y[43]) begin
      ys  = v.y >>> i;
      o.x = v.x + ys;
      o.y = v.y - xs;
      o.z = v.z + $signed({4'b0000, atan_q30(i)});
    end else begin
      ys  = ny >>> i;
      o.x = v.x + ys;
      o.y = v.y + xs;
      o.z = v.z - $signed({4'b0000, atan_q30(i)});
    end
    return o;
  endfunction

  function automatic co_t co_stage(input co_t v, input int unsigned i);
    co_t o;
    o   = v;
    o.a = cv_step(v.a, i);
    o.b = cv_step(v.b, i);
    return o;
  endfunction

  function automatic logic [5:0] msb64(input logic [63:0] v);
    logic [5:0] m;
    m = '0;
    for (int j = 0; j < 64; j++) begin
      if (v[j]) m = 6'(j);
    end
    return m;
  endfunction

  // Place the leading one at bit 39
  function automatic logic [39:0] norm40(input logic [63:0] v, input logic [5:0] msb);
    logic [39:0] o;
    if (msb > 6'd39) begin
      o = 40'(v >> (msb - 6'd39));
    end else begin
      o = 40'(v << (6'd39 - msb));
    end
    return o;
  endfunction

  // Clamp, mirror for negative x and round Q30 to Q28
  function automatic logic [30:0] ang_q28(input cv_t v, input logic neg, input logic zero);
    logic [31:0] zc;
    logic [32:0] w;
    if (v.z < 0) begin
      zc = '0;
    end else if (v.z > $signed({2'b00, HALF_PI_Q30})) begin
      zc = HALF_PI_Q30;
    end else begin
      zc = v.z[31:0];
    end
    if (zero) begin
      w = '0;
    end else if (neg) begin
      w = {1'b0, PI_Q30 - zc};
    end else begin
      w = {1'b0, zc};
    end
    return 31'((w + 33'd2) >> 2);
  endfunction

  // One quotient bit of the restoring division
  function automatic dv_t dv_step(input dv_t v);
    logic [64:0] rs;
    dv_t         o;
    o  = v;
    rs = {v.rem[63:0], 1'b0};
    if (rs >= {1'b0, v.den}) begin
      o.rem = rs - {1'b0, v.den};
      o.q   = {v.q[QW-2:0], 1'b1};
    end else begin
      o.rem = rs;
      o.q   = {v.q[QW-2:0], 1'b0};
    end
    return o;
  endfunction

  // ---------------------------------------------------------------- stage enables
  logic s1_en, s2_en, s3_en, s4_en, s5_en, s6_en;
  logic sm_en, n1_en, n2_en, n3_en, af_en, ml_en, ad_en, d0_en, out_en;
  logic sq_en [SQRT_STEPS];
  logic co_en [CORDIC_STEPS];
  logic dv_en [QW];

  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r;
  logic sm_v_r, n1_v_r, n2_v_r, n3_v_r, af_v_r, ml_v_r, ad_v_r, d0_v_r, out_v_r;
  logic sq_v_r [SQRT_STEPS];
  logic co_v_r [CORDIC_STEPS];
  logic dv_v_r [QW];

  assign out_en    = !out_v_r || out_tready;
  assign d0_en     = !d0_v_r || dv_en[0];
  assign ad_en     = !ad_v_r || d0_en;
  assign ml_en     = !ml_v_r || ad_en;
  assign af_en     = !af_v_r || ml_en;
  assign n3_en     = !n3_v_r || co_en[0];
  assign n2_en     = !n2_v_r || n3_en;
  assign n1_en     = !n1_v_r || n2_en;
  assign sm_en     = !sm_v_r || n1_en;
  assign s6_en     = !s6_v_r || sq_en[0];
  assign s5_en     = !s5_v_r || s6_en;
  assign s4_en     = !s4_v_r || s5_en;
  assign s3_en     = !s3_v_r || s4_en;
  assign s2_en     = !s2_v_r || s3_en;
  assign s1_en     = !s1_v_r || s2_en;
  assign in_tready = s1_en;

  // ---------------------------------------------------------------- stage 1: distances
  logic [CW-1:0] tx, ty, tr, sx, sy, sr;
  logic [CW:0]   dx_nxt, dy_nxt, adx_nxt, ady_nxt;
  logic [VW-1:0] s1_a_r, s1_b_r, s1_br_r, s1_sr_r;

  always_comb begin
    tx      = in_tdata[CW-1:0];
    ty      = in_tdata[2*CW-1:CW];
    tr      = in_tdata[3*CW-1:2*CW];
    sx      = in_tdata[4*CW-1:3*CW];
    sy      = in_tdata[5*CW-1:4*CW];
    sr      = in_tdata[6*CW-1:5*CW];
    dx_nxt  = {tx[CW-1], tx} - {sx[CW-1], sx};
    dy_nxt  = {ty[CW-1], ty} - {sy[CW-1], sy};
    adx_nxt = dx_nxt[CW] ? (~dx_nxt + 1'b1) : dx_nxt;
    ady_nxt = dy_nxt[CW] ? (~dy_nxt + 1'b1) : dy_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_en) begin
      s1_v_r <= in_tvalid;
    end
    if (s1_en) begin
      s1_a_r  <= VW'(adx_nxt[CW-1:0]);
      s1_b_r  <= VW'(ady_nxt[CW-1:0]);
      s1_br_r <= VW'(tr);
      s1_sr_r <= VW'(sr);
    end
  end

  // ---------------------------------------------------------------- stage 2: range shift amount
  logic [VW-1:0]  or_v;
  logic [SHW-1:0] blen, sh_nxt;
  logic [VW-1:0]  s2_a_r, s2_b_r, s2_br_r, s2_sr_r;
  logic [SHW-1:0] s2_sh_r;

  always_comb begin
    or_v = s1_a_r | s1_b_r | s1_br_r | s1_sr_r;
    blen = '0;
    for (int j = 0; j < VW; j++) begin
      if (or_v[j]) blen = SHW'(j + 1);
    end
    sh_nxt = (blen > SHW'(NW)) ? blen - SHW'(NW) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_en) begin
      s2_v_r <= s1_v_r;
    end
    if (s2_en) begin
      s2_a_r  <= s1_a_r;
      s2_b_r  <= s1_b_r;
      s2_br_r <= s1_br_r;
      s2_sr_r <= s1_sr_r;
      s2_sh_r <= sh_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 3: bring below 2^16
  logic [NW-1:0] s3_a_r, s3_b_r, s3_br_r, s3_sr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_en) begin
      s3_v_r <= s2_v_r;
    end
    if (s3_en) begin
      s3_a_r  <= NW'(s2_a_r >> s2_sh_r);
      s3_b_r  <= NW'(s2_b_r >> s2_sh_r);
      s3_br_r <= NW'(s2_br_r >> s2_sh_r);
      s3_sr_r <= NW'(s2_sr_r >> s2_sh_r);
    end
  end

  // ---------------------------------------------------------------- stage 4: squares
  logic [31:0] s4_aa_r, s4_bb_r, s4_rr2_r, s4_sr2_r;
  logic [16:0] s4_sum_r;
  logic [15:0] s4_diff_r;
  logic        s4_le_r, s4_ge_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (s4_en) begin
      s4_v_r <= s3_v_r;
    end
    if (s4_en) begin
      s4_aa_r   <= s3_a_r * s3_a_r;
      s4_bb_r   <= s3_b_r * s3_b_r;
      s4_rr2_r  <= s3_br_r * s3_br_r;
      s4_sr2_r  <= s3_sr_r * s3_sr_r;
      s4_sum_r  <= {1'b0, s3_br_r} + {1'b0, s3_sr_r};
      s4_diff_r <= (s3_br_r >= s3_sr_r) ? s3_br_r - s3_sr_r : s3_sr_r - s3_br_r;
      s4_le_r   <= s3_sr_r <= s3_br_r;
      s4_ge_r   <= s3_sr_r >= s3_br_r;
    end
  end

  // ---------------------------------------------------------------- stage 5: squared distance, bounds
  logic [32:0] s5_d2_r;
  logic [33:0] s5_sumsq_r;
  logic [31:0] s5_diffsq_r, s5_rr2_r, s5_sr2_r;
  logic        s5_le_r, s5_ge_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (s5_en) begin
      s5_v_r <= s4_v_r;
    end
    if (s5_en) begin
      s5_d2_r     <= {1'b0, s4_aa_r} + {1'b0, s4_bb_r};
      s5_sumsq_r  <= s4_sum_r * s4_sum_r;
      s5_diffsq_r <= s4_diff_r * s4_diff_r;
      s5_rr2_r    <= s4_rr2_r;
      s5_sr2_r    <= s4_sr2_r;
      s5_le_r     <= s4_le_r;
      s5_ge_r     <= s4_ge_r;
    end
  end

  // ---------------------------------------------------------------- stage 6: classify
  kind_t              kind_nxt;
  kind_t              s6_kind_r;
  logic [33:0]        s6_p_r;
  logic [32:0]        s6_q_r;
  logic signed [34:0] s6_x1_r, s6_x2_r;
  logic [31:0]        s6_rr2_r, s6_sr2_r;

  always_comb begin
    priority if (s5_le_r && s5_d2_r <= {1'b0, s5_diffsq_r}) begin
      kind_nxt = K_ONE;
    end else if ({1'b0, s5_d2_r} >= s5_sumsq_r && s5_d2_r > {1'b0, s5_rr2_r}) begin
      kind_nxt = K_ZERO;
    end else if (s5_ge_r && s5_d2_r <= {1'b0, s5_diffsq_r}) begin
      kind_nxt = K_RATIO;
    end else begin
      kind_nxt = K_LENS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else if (s6_en) begin
      s6_v_r <= s5_v_r;
    end
    if (s6_en) begin
      s6_kind_r <= kind_nxt;
      s6_p_r    <= (s5_sumsq_r > {1'b0, s5_d2_r}) ? s5_sumsq_r - {1'b0, s5_d2_r} : '0;
      s6_q_r    <= (s5_d2_r > {1'b0, s5_diffsq_r}) ? s5_d2_r - {1'b0, s5_diffsq_r} : '0;
      s6_x1_r   <= $signed({2'b00, s5_d2_r}) + $signed({3'b000, s5_sr2_r})
                   - $signed({3'b000, s5_rr2_r});
      s6_x2_r   <= $signed({2'b00, s5_d2_r}) + $signed({3'b000, s5_rr2_r})
                   - $signed({3'b000, s5_sr2_r});
      s6_rr2_r  <= s5_rr2_r;
      s6_sr2_r  <= s5_sr2_r;
    end
  end

  // ---------------------------------------------------------------- square roots, one digit a stage
  sq_t sq_in;
  sq_t sq_r [SQRT_STEPS];

  always_comb begin
    sq_in.p.rad    = {2'b00, s6_p_r, 28'd0};
    sq_in.p.rem    = '0;
    sq_in.p.root   = '0;
    sq_in.q.rad    = {5'd0, s6_q_r, 26'd0};
    sq_in.q.rem    = '0;
    sq_in.q.root   = '0;
    sq_in.x1       = s6_x1_r;
    sq_in.x2       = s6_x2_r;
    sq_in.side     = '{kind: s6_kind_r, rr2: s6_rr2_r, sr2: s6_sr2_r};
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sq
    sq_t  src;
    logic vsrc;
    logic en_next;
    if (k == 0) begin : g_head
      assign src  = sq_in;
      assign vsrc = s6_v_r;
    end else begin : g_tail
      assign src  = sq_r[k-1];
      assign vsrc = sq_v_r[k-1];
    end
    if (k == SQRT_STEPS - 1) begin : g_last
      assign en_next = sm_en;
    end else begin : g_mid
      assign en_next = sq_en[k+1];
    end
    assign sq_en[k] = !sq_v_r[k] || en_next;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k] <= 1'b0;
      end else if (sq_en[k]) begin
        sq_v_r[k] <= vsrc;
      end
      if (sq_en[k]) begin
        sq_r[k] <= sq_stage(src);
      end
    end
  end

  // ---------------------------------------------------------------- half chord product
  logic [63:0]        sm_s_r;
  logic signed [34:0] sm_x1_r, sm_x2_r;
  side_t              sm_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sm_v_r <= 1'b0;
    end else if (sm_en) begin
      sm_v_r <= sq_v_r[SQRT_STEPS-1];
    end
    if (sm_en) begin
      sm_s_r    <= sq_r[SQRT_STEPS-1].p.root * sq_r[SQRT_STEPS-1].q.root;
      sm_x1_r   <= sq_r[SQRT_STEPS-1].x1;
      sm_x2_r   <= sq_r[SQRT_STEPS-1].x2;
      sm_side_r <= sq_r[SQRT_STEPS-1].side;
    end
  end

  // ---------------------------------------------------------------- normalize: magnitudes and max
  logic [34:0] ax1, ax2;
  logic [63:0] xm1_nxt, xm2_nxt;
  logic [63:0] n1_xm1_r, n1_xm2_r, n1_m1_r, n1_m2_r, n1_s_r;
  logic        n1_aneg_r, n1_bneg_r;
  side_t       n1_side_r;

  always_comb begin
    ax1     = sm_x1_r[34] ? 35'(-sm_x1_r) : 35'(sm_x1_r);
    ax2     = sm_x2_r[34] ? 35'(-sm_x2_r) : 35'(sm_x2_r);
    xm1_nxt = {2'b00, ax1, 27'd0};
    xm2_nxt = {2'b00, ax2, 27'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n1_v_r <= 1'b0;
    end else if (n1_en) begin
      n1_v_r <= sm_v_r;
    end
    if (n1_en) begin
      n1_xm1_r  <= xm1_nxt;
      n1_xm2_r  <= xm2_nxt;
      n1_m1_r   <= (xm1_nxt > sm_s_r) ? xm1_nxt : sm_s_r;
      n1_m2_r   <= (xm2_nxt > sm_s_r) ? xm2_nxt : sm_s_r;
      n1_s_r    <= sm_s_r;
      n1_aneg_r <= sm_x1_r[34];
      n1_bneg_r <= sm_x2_r[34];
      n1_side_r <= sm_side_r;
    end
  end

  // ---------------------------------------------------------------- normalize: leading one
  logic [63:0] n2_xm1_r, n2_xm2_r, n2_s_r;
  logic [5:0]  n2_msb1_r, n2_msb2_r;
  logic        n2_z1_r, n2_z2_r, n2_aneg_r, n2_bneg_r;
  side_t       n2_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n2_v_r <= 1'b0;
    end else if (n2_en) begin
      n2_v_r <= n1_v_r;
    end
    if (n2_en) begin
      n2_xm1_r  <= n1_xm1_r;
      n2_xm2_r  <= n1_xm2_r;
      n2_s_r    <= n1_s_r;
      n2_msb1_r <= msb64(n1_m1_r);
      n2_msb2_r <= msb64(n1_m2_r);
      n2_z1_r   <= n1_m1_r == '0;
      n2_z2_r   <= n1_m2_r == '0;
      n2_aneg_r <= n1_aneg_r;
      n2_bneg_r <= n1_bneg_r;
      n2_side_r <= n1_side_r;
    end
  end

  // ---------------------------------------------------------------- normalize: shift
  co_t n3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n3_v_r <= 1'b0;
    end else if (n3_en) begin
      n3_v_r <= n2_v_r;
    end
    if (n3_en) begin
      n3_r.a.x   <= {4'b0000, norm40(n2_xm1_r, n2_msb1_r)};
      n3_r.a.y   <= {4'b0000, norm40(n2_s_r, n2_msb1_r)};
      n3_r.a.z   <= '0;
      n3_r.b.x   <= {4'b0000, norm40(n2_xm2_r, n2_msb2_r)};
      n3_r.b.y   <= {4'b0000, norm40(n2_s_r, n2_msb2_r)};
      n3_r.b.z   <= '0;
      n3_r.aneg  <= n2_aneg_r;
      n3_r.bneg  <= n2_bneg_r;
      n3_r.azero <= n2_z1_r;
      n3_r.bzero <= n2_z2_r;
      n3_r.s     <= n2_s_r;
      n3_r.side  <= n2_side_r;
    end
  end

  // ---------------------------------------------------------------- CORDIC, one rotation a stage
  co_t co_r [CORDIC_STEPS];

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_co
    co_t  src;
    logic vsrc;
    logic en_next;
    if (k == 0) begin : g_head
      assign src  = n3_r;
      assign vsrc = n3_v_r;
    end else begin : g_tail
      assign src  = co_r[k-1];
      assign vsrc = co_v_r[k-1];
    end
    if (k == CORDIC_STEPS - 1) begin : g_last
      assign en_next = af_en;
    end else begin : g_mid
      assign en_next = co_en[k+1];
    end
    assign co_en[k] = !co_v_r[k] || en_next;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        co_v_r[k] <= 1'b0;
      end else if (co_en[k]) begin
        co_v_r[k] <= vsrc;
      end
      if (co_en[k]) begin
        co_r[k] <= co_stage(src, k);
      end
    end
  end

  // ---------------------------------------------------------------- finish half angles
  logic [30:0] af_alpha_r, af_beta_r;
  logic [63:0] af_s_r;
  side_t       af_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      af_v_r <= 1'b0;
    end else if (af_en) begin
      af_v_r <= co_v_r[CORDIC_STEPS-1];
    end
    if (af_en) begin
      af_alpha_r <= ang_q28(co_r[CORDIC_STEPS-1].a, co_r[CORDIC_STEPS-1].aneg,
                            co_r[CORDIC_STEPS-1].azero);
      af_beta_r  <= ang_q28(co_r[CORDIC_STEPS-1].b, co_r[CORDIC_STEPS-1].bneg,
                            co_r[CORDIC_STEPS-1].bzero);
      af_s_r     <= co_r[CORDIC_STEPS-1].s;
      af_side_r  <= co_r[CORDIC_STEPS-1].side;
    end
  end

  // ---------------------------------------------------------------- sector areas and disc area
  logic [62:0] ml_n1_r, ml_n2_r;
  logic [61:0] ml_den_r;
  logic [63:0] ml_s_r;
  side_t       ml_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ml_v_r <= 1'b0;
    end else if (ml_en) begin
      ml_v_r <= af_v_r;
    end
    if (ml_en) begin
      ml_n1_r   <= af_side_r.sr2 * af_alpha_r;
      ml_n2_r   <= af_side_r.rr2 * af_beta_r;
      ml_den_r  <= af_side_r.sr2 * PI_Q28;
      ml_s_r    <= af_s_r;
      ml_side_r <= af_side_r;
    end
  end

  // ---------------------------------------------------------------- lens area, pick the quotient
  logic [64:0] nsum, lens;
  logic [63:0] num_nxt, den_nxt;
  logic [63:0] ad_num_r, ad_den_r;

  always_comb begin
    nsum = {2'b00, ml_n1_r} + {2'b00, ml_n2_r};
    lens = (nsum > {1'b0, ml_s_r}) ? nsum - {1'b0, ml_s_r} : '0;
    unique case (ml_side_r.kind)
      K_ONE: begin
        num_nxt = 64'd1;
        den_nxt = 64'd1;
      end
      K_ZERO: begin
        num_nxt = '0;
        den_nxt = '0;
      end
      K_RATIO: begin
        num_nxt = 64'(ml_side_r.rr2);
        den_nxt = 64'(ml_side_r.sr2);
      end
      K_LENS: begin
        num_nxt = lens[63:0];
        den_nxt = 64'(ml_den_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ad_v_r <= 1'b0;
    end else if (ad_en) begin
      ad_v_r <= ml_v_r;
    end
    if (ad_en) begin
      ad_num_r <= num_nxt;
      ad_den_r <= den_nxt;
    end
  end

  // ---------------------------------------------------------------- divider setup
  dv_t d0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d0_v_r <= 1'b0;
    end else if (d0_en) begin
      d0_v_r <= ad_v_r;
    end
    if (d0_en) begin
      d0_r.rem   <= {1'b0, ad_num_r};
      d0_r.den   <= ad_den_r;
      d0_r.q     <= '0;
      d0_r.done  <= (ad_den_r == '0) || (ad_num_r >= ad_den_r);
      d0_r.fixed <= (ad_den_r == '0) ? '0 : QW'(1) << FB;
    end
  end

  // ---------------------------------------------------------------- divider, one bit a stage
  dv_t dv_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_dv
    dv_t  src;
    logic vsrc;
    logic en_next;
    if (k == 0) begin : g_head
      assign src  = d0_r;
      assign vsrc = d0_v_r;
    end else begin : g_tail
      assign src  = dv_r[k-1];
      assign vsrc = dv_v_r[k-1];
    end
    if (k == QW - 1) begin : g_last
      assign en_next = out_en;
    end else begin : g_mid
      assign en_next = dv_en[k+1];
    end
    assign dv_en[k] = !dv_v_r[k] || en_next;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k] <= 1'b0;
      end else if (dv_en[k]) begin
        dv_v_r[k] <= vsrc;
      end
      if (dv_en[k]) begin
        dv_r[k] <= dv_step(src);
      end
    end
  end

  // ---------------------------------------------------------------- round and hold the result
  logic [QW:0]   qr;
  logic [QW-1:0] res_nxt;
  logic [QW-1:0] out_res_r;

  always_comb begin
    qr      = ({1'b0, dv_r[QW-1].q} + 1'b1) >> 1;
    res_nxt = dv_r[QW-1].done ? dv_r[QW-1].fixed : qr[QW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_en) begin
      out_v_r <= dv_v_r[QW-1];
    end
    if (out_en) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_W'(out_res_r);

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import cof_pkg::*;

  typedef struct packed {
    logic [15:0] spread_rad;
    logic [15:0] spread_y;
    logic [15:0] spread_x;
    logic [15:0] target_rad;
    logic [15:0] target_y;
    logic [15:0] target_x;
  } circles_t;

  localparam longint unsigned PI_Q28_L = 64'd843314857;
  localparam longint unsigned PI_Q30_L = 64'd3373259426;
  localparam longint unsigned HALF_PI_Q30_L = 64'd1686629713;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  wire         in_tready;
  logic [95:0] in_tdata;
  wire         out_tvalid;
  logic        out_tready;
  wire  [23:0] out_tdata;

  circles_t    pending_items[$];
  logic [16:0] expected_fractions[$];
  int          errors = 0;
  int          results_seen = 0;
  bit          quiet_tail = 0;
  int          send_gap = 0;
  int          recv_gap = 0;
  int          hold_off = 0;
  bit          hold_done = 0;
  bit          in_taken = 0;

  circle_overlap_fraction uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // Integer square root, bit by bit
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Restoring division to a rounded fraction, saturated at one
  function automatic longint unsigned ratio_q16(input longint unsigned num,
                                                input longint unsigned den);
    longint unsigned rem, q;
    if (den == 0) return 0;
    if (num >= den) return 64'd1 << 16;
    rem = num;
    q = 0;
    for (int i = 0; i <= 16; i++) begin
      rem <<= 1;
      q <<= 1;
      if (rem >= den) begin
        rem -= den;
        q |= 1;
      end
    end
    return (q + 1) >> 1;
  endfunction

  // Vectoring CORDIC: angle of (+/-xm, y) in Q30
  function automatic longint unsigned angle_q30(input longint unsigned y_in,
                                                input longint unsigned xm_in,
                                                input bit xneg);
    longint unsigned m, xm, yu;
    longint x, yy, z, xs;
    xm = xm_in;
    yu = y_in;
    m = (xm > yu) ? xm : yu;
    z = 0;
    if (m == 0) return 0;
    while (m >= (64'd1 << 40)) begin
      xm >>= 1; yu >>= 1; m >>= 1;
    end
    while (m < (64'd1 << 39)) begin
      xm <<= 1; yu <<= 1; m <<= 1;
    end
    x = longint'(xm);
    yy = longint'(yu);
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      if (yy >= 0) begin
        x = x + (yy >>> i);
        yy = yy - xs;
        z = z + longint'(atan_q30(i));
      end else begin
        x = x + ((-yy) >>> i);
        yy = yy + xs;
        z = z - longint'(atan_q30(i));
      end
    end
    if (z < 0) z = 0;
    if (z > longint'(HALF_PI_Q30_L)) z = longint'(HALF_PI_Q30_L);
    return xneg ? (PI_Q30_L - longint'(z)) : longint'(z);
  endfunction

  function automatic longint unsigned half_angle(input longint unsigned s, input longint xv);
    bit neg;
    longint unsigned mag;
    neg = xv < 0;
    mag = longint'(neg ? -xv : xv) << 27;
    return (angle_q30(s, mag, neg) + 2) >> 2;
  endfunction

  // Fraction of the spread disc that lies inside the target disc
  function automatic logic [16:0] overlap_fraction(input circles_t c);
    longint dx, dy;
    longint unsigned a, b, big_r, r, d2, rr2, sr2, sum, diff, res;
    longint unsigned p, q, s, alpha, beta, n;
    longint x1, x2;
    dx = longint'($signed(c.target_x)) - longint'($signed(c.spread_x));
    dy = longint'($signed(c.target_y)) - longint'($signed(c.spread_y));
    a = dx < 0 ? -dx : dx;
    b = dy < 0 ? -dy : dy;
    big_r = c.target_rad;
    r = c.spread_rad;
    while (a >= 65536 || b >= 65536 || big_r >= 65536 || r >= 65536) begin
      a >>= 1; b >>= 1; big_r >>= 1; r >>= 1;
    end
    d2 = a * a + b * b;
    rr2 = big_r * big_r;
    sr2 = r * r;
    sum = big_r + r;
    diff = (big_r >= r) ? big_r - r : r - big_r;
    if (r <= big_r && d2 <= diff * diff) begin
      res = 64'd1 << 16;
    end else if (d2 >= sum * sum && d2 > rr2) begin
      res = 0;
    end else if (r >= big_r && d2 <= diff * diff) begin
      res = ratio_q16(rr2, sr2);
    end else begin
      p = (sum * sum > d2) ? sum * sum - d2 : 0;
      q = (d2 > diff * diff) ? d2 - diff * diff : 0;
      s = int_sqrt(p << 28) * int_sqrt(q << 26);
      x1 = longint'(d2) + longint'(sr2) - longint'(rr2);
      x2 = longint'(d2) + longint'(rr2) - longint'(sr2);
      alpha = half_angle(s, x1);
      beta = half_angle(s, x2);
      n = sr2 * alpha + rr2 * beta;
      n = (n > s) ? n - s : 0;
      res = ratio_q16(n, PI_Q28_L * sr2);
    end
    return res[16:0];
  endfunction

  function automatic circles_t pair_of(input int tx, input int ty, input int tr,
                                       input int sx, input int sy, input int sr);
    circles_t c;
    c.target_x = tx[15:0];
    c.target_y = ty[15:0];
    c.target_rad = tr[15:0];
    c.spread_x = sx[15:0];
    c.spread_y = sy[15:0];
    c.spread_rad = sr[15:0];
    return c;
  endfunction

  // Random pair, mostly near each other so that all cases appear
  function automatic circles_t random_pair();
    circles_t c;
    int tx, ty, tr, sr, span;
    if ($urandom_range(0, 4) == 0) begin
      c = {$urandom, $urandom, $urandom};
    end else begin
      span = $urandom_range(0, 1) ? 2048 : 16384;
      tx = $urandom_range(0, 2 * span) - span;
      ty = $urandom_range(0, 2 * span) - span;
      tr = $urandom_range(0, span);
      sr = $urandom_range(0, span);
      c = pair_of(tx, ty, tr,
                  tx + $urandom_range(0, 2 * (tr + sr)) - (tr + sr),
                  ty + $urandom_range(0, 2 * (tr + sr)) - (tr + sr), sr);
    end
    return c;
  endfunction

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Record accepted items and their expected fractions
  always @(posedge clk) begin
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      expected_fractions.push_back(overlap_fraction(pending_items[0]));
      void'(pending_items.pop_front());
    end
  end

  // Drive the input channel with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_taken) begin
      in_tvalid <= 1'b1;
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      in_tvalid <= 1'b0;
    end else if (pending_items.size() > 0) begin
      in_tvalid <= 1'b1;
      in_tdata <= pending_items[0];
      if (!quiet_tail && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 10);
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Stall the result channel with random gaps, and once for a long stretch
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else if (!hold_done && results_seen >= 150) begin
      hold_done <= 1;
      hold_off <= 300;
      out_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (!quiet_tail && $urandom_range(0, 9) == 0) recv_gap <= $urandom_range(1, 10);
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen <= results_seen + 1;
      if (expected_fractions.size() == 0) begin
        errors++;
        $display("%t: unexpected result, expected none, got %0d", $time, out_tdata[16:0]);
      end else begin
        if (out_tdata[16:0] !== expected_fractions[0]) begin
          errors++;
          $display("%t: hit_fraction expected %0d, got %0d", $time,
                   expected_fractions[0], out_tdata[16:0]);
        end
        void'(expected_fractions.pop_front());
      end
    end
  end

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    out_tready = 0;
    // Zero radii, coincident, nested both ways, tangent, disjoint, extremes
    pending_items.push_back(pair_of(0, 0, 0, 0, 0, 0));
    pending_items.push_back(pair_of(100, 100, 500, 100, 100, 0));
    pending_items.push_back(pair_of(0, 0, 0, 256, 0, 0));
    pending_items.push_back(pair_of(0, 0, 256, 0, 0, 256));
    pending_items.push_back(pair_of(0, 0, 1024, 128, 0, 256));
    pending_items.push_back(pair_of(0, 0, 256, 128, 0, 1024));
    pending_items.push_back(pair_of(0, 0, 0, 0, 0, 1024));
    pending_items.push_back(pair_of(0, 0, 256, 512, 0, 256));
    pending_items.push_back(pair_of(0, 0, 256, 1000, 0, 256));
    pending_items.push_back(pair_of(0, 0, 768, 512, 0, 256));
    pending_items.push_back(pair_of(0, 0, 256, 300, 0, 256));
    pending_items.push_back(pair_of(0, 0, 256, 0, 400, 1000));
    pending_items.push_back(pair_of(0, 0, 1000, 0, 900, 256));
    pending_items.push_back(pair_of(-32768, -32768, 65535, 32767, 32767, 65535));
    pending_items.push_back(pair_of(32767, 32767, 0, -32768, -32768, 65535));
    pending_items.push_back(pair_of(-32768, 32767, 65535, 32767, -32768, 0));
    pending_items.push_back(pair_of(0, 0, 65535, 0, 0, 65535));
    pending_items.push_back(pair_of(1, 1, 1, 0, 0, 1));
    pending_items.push_back(pair_of(-5000, 3000, 2000, -4000, 3500, 1500));
    pending_items.push_back(pair_of(0, 0, 1, 32767, 0, 32767));
    for (int i = 0; i < 700; i++) pending_items.push_back(random_pair());
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n = 1;
    wait (pending_items.size() < 100);
    quiet_tail = 1;
    wait (pending_items.size() == 0 && expected_fractions.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_fractions.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #800000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire

@@ sim.f @@
rtl/cof_pkg.sv
rtl/circle_overlap_fraction.sv
bench/tb_top.sv
